// File: rtl/gdad_pkg.sv
// Package for the Gregorian date adder: field widths, calendar constants,
// payload structs and the controller/datapath command and status structs.
// No dependencies.
`default_nettype none

package gdad_pkg;

	localparam int DAY_W          = 5;
	localparam int MONTH_W        = 4;
	localparam int YEAR_W         = 12;
	localparam int OFFSET_FIELD_W = 12;

	// month codes
	localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
	localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
	localparam logic [MONTH_W-1:0] MONTH_APR = 4'd4;
	localparam logic [MONTH_W-1:0] MONTH_JUN = 4'd6;
	localparam logic [MONTH_W-1:0] MONTH_SEP = 4'd9;
	localparam logic [MONTH_W-1:0] MONTH_NOV = 4'd11;
	localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

	// month lengths
	localparam logic [DAY_W-1:0] LEN_LONG  = 5'd31;
	localparam logic [DAY_W-1:0] LEN_SHORT = 5'd30;
	localparam logic [DAY_W-1:0] LEN_LEAP  = 5'd29;
	localparam logic [DAY_W-1:0] LEN_FEB   = 5'd28;

	// year modulo 400 bookkeeping
	localparam logic [YEAR_W-1:0] YEAR_LAST  = 12'hFFF;
	localparam logic [YEAR_W-1:0] CYCLE_LAST = 12'd399;
	localparam logic [YEAR_W-1:0] CENT_1     = 12'd100;
	localparam logic [YEAR_W-1:0] CENT_2     = 12'd200;
	localparam logic [YEAR_W-1:0] CENT_3     = 12'd300;

	// compare-subtract steps that reduce a 12-bit year modulo 400
	localparam int RED_STEPS = 4;
	localparam int RED_SEL_W = $clog2(RED_STEPS);
	localparam logic [YEAR_W-1:0] RED_STEP [RED_STEPS] = '{
		12'd3200, 12'd1600, 12'd800, 12'd400
	};

	typedef struct packed {
		logic [DAY_W-1:0]          start_day;
		logic [MONTH_W-1:0]        start_month;
		logic [YEAR_W-1:0]         start_year;
		logic [OFFSET_FIELD_W-1:0] days_ahead;
	} date_in_t;

	typedef struct packed {
		logic [DAY_W-1:0]   end_day;
		logic [MONTH_W-1:0] end_month;
		logic [YEAR_W-1:0]  end_year;
	} date_out_t;

	typedef struct packed {
		logic                 load;
		logic                 reduce;
		logic [RED_SEL_W-1:0] red_sel;
		logic                 step;
	} dp_cmd_t;

	typedef struct packed {
		logic fits;
	} dp_stat_t;

endpackage

`default_nettype wire

// File: rtl/gregorian_date_add_days_top.sv
// Top level of the Gregorian date adder: joins controller and datapath.
// Depends on gdad_pkg, gdad_ctrl and gdad_dp.
`default_nettype none

// Adds days_ahead to a Gregorian date. A transaction is taken when start is
// high and busy is low. The block then reduces the year modulo 400 for the
// leap rule by compare-subtract steps on the year-mod-400 register, and steps
// once for every month boundary the offset crosses plus one final check,
// through a single subtract and compare on the day accumulator. done is high
// for exactly one cycle, in the same cycle busy falls, with the date on result;
// it cannot be held off, so the receiver must take it in that cycle. A new
// transaction may start in the done cycle. The number of month boundaries
// crossed is at most 135 for a 12-bit offset.
module gregorian_date_add_days_top #(
	parameter int OFFSET_BITS = 12
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 start,
	input  gdad_pkg::date_in_t  item,
	output logic                busy,
	output logic                done,
	output gdad_pkg::date_out_t result
);
	import gdad_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	gdad_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	gdad_dp #(
		.OFFSET_BITS (OFFSET_BITS)
	) u_dp (
		.clk    (clk),
		.cmd    (cmd),
		.item   (item),
		.stat   (stat),
		.result (result)
	);

endmodule

`default_nettype wire

// File: rtl/gdad_dp.sv
// Datapath of the Gregorian date adder: day accumulator, month and year
// registers, year-mod-400 register and the month length decode.
// Depends on gdad_pkg.
`default_nettype none

module gdad_dp #(
	parameter int OFFSET_BITS = 12
) (
	input  wire                 clk,
	input  gdad_pkg::dp_cmd_t   cmd,
	input  gdad_pkg::date_in_t  item,
	output gdad_pkg::dp_stat_t  stat,
	output gdad_pkg::date_out_t result
);
	import gdad_pkg::*;

	localparam int EFF_BITS  = (OFFSET_BITS < OFFSET_FIELD_W) ? OFFSET_BITS : OFFSET_FIELD_W;
	localparam int DAY_ACC_W = ((EFF_BITS > DAY_W) ? EFF_BITS : DAY_W) + 1;

	logic [DAY_ACC_W-1:0] day_q;
	logic [MONTH_W-1:0]   month_q;
	logic [YEAR_W-1:0]    year_q;
	logic [YEAR_W-1:0]    ymod_q;   // year modulo 400

	logic                 leap;
	logic [DAY_W-1:0]     len;
	logic [YEAR_W-1:0]    red_const;

	assign leap = (year_q[1:0] == 2'b00) && (ymod_q != CENT_1) &&
		(ymod_q != CENT_2) && (ymod_q != CENT_3);

	always_comb begin
		case (month_q) inside
			MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: len = LEN_SHORT;
			MONTH_FEB:                                  len = leap ? LEN_LEAP : LEN_FEB;
			default:                                    len = LEN_LONG;
		endcase
	end

	assign red_const = RED_STEP[cmd.red_sel];
	assign stat.fits = (day_q <= DAY_ACC_W'(len));

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			day_q   <= DAY_ACC_W'(item.start_day) +
				DAY_ACC_W'(item.days_ahead[EFF_BITS-1:0]);
			month_q <= item.start_month;
			year_q  <= item.start_year;
			ymod_q  <= item.start_year;
		end else if (cmd.reduce) begin
			if (ymod_q >= red_const) begin
				ymod_q <= ymod_q - red_const;
			end
		end else if (cmd.step) begin
			day_q <= day_q - DAY_ACC_W'(len);
			if (month_q >= MONTH_DEC) begin
				// wrap to January of the next year
				month_q <= MONTH_JAN;
				year_q  <= year_q + 1'b1;
				if (year_q == YEAR_LAST || ymod_q == CYCLE_LAST) begin
					ymod_q <= '0;
				end else begin
					ymod_q <= ymod_q + 1'b1;
				end
			end else begin
				month_q <= month_q + 1'b1;
			end
		end
	end

	assign result.end_day   = day_q[DAY_W-1:0];
	assign result.end_month = month_q;
	assign result.end_year  = year_q;

endmodule

`default_nettype wire

// File: rtl/gdad_ctrl.sv
// Controller of the Gregorian date adder: sequences the load, the year
// reduction steps and the month steps, and raises done.
// Depends on gdad_pkg.
`default_nettype none

module gdad_ctrl (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                start,
	input  gdad_pkg::dp_stat_t stat,
	output gdad_pkg::dp_cmd_t  cmd,
	output logic               busy,
	output logic               done
);
	import gdad_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_REDUCE,
		ST_STEP
	} state_t;

	state_t               state_q;
	logic [RED_SEL_W-1:0] red_cnt_q;
	logic                 busy_q;
	logic                 done_q;

	always_comb begin
		cmd.load    = (state_q == ST_IDLE) && start;
		cmd.reduce  = (state_q == ST_REDUCE);
		cmd.red_sel = red_cnt_q;
		cmd.step    = (state_q == ST_STEP) && !stat.fits;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			red_cnt_q <= '0;
			busy_q    <= 1'b0;
			done_q    <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q   <= ST_REDUCE;
						red_cnt_q <= '0;
						busy_q    <= 1'b1;
					end
				end
				ST_REDUCE: begin
					red_cnt_q <= red_cnt_q + 1'b1;
					if (red_cnt_q == RED_SEL_W'(RED_STEPS - 1)) begin
						state_q <= ST_STEP;
					end
				end
				ST_STEP: begin
					// hold stepping until the day fits its month
					if (stat.fits) begin
						state_q <= ST_IDLE;
						busy_q  <= 1'b0;
						done_q  <= 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
					busy_q  <= 1'b0;
				end
			endcase
		end
	end

	assign busy = busy_q;
	assign done = done_q;

endmodule

`default_nettype wire

// File: rtl/gdad_chk.sv
// Port-level checker for the Gregorian date adder and its bind to the top.
// Depends on gregorian_date_add_days_top.
`default_nettype none

module gdad_chk (
	input wire clk,
	input wire arst_n,
	input wire start,
	input wire busy,
	input wire done
);

	// result shows only once the block is idle again
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("done while busy");

	// an accepted transaction makes the block busy
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("busy did not rise after accept");

	// no result right after an accept
	a_accept_no_done: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> !done)
		else $error("done right after accept");

	// done is a single-cycle strobe
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done held for more than one cycle");

	// done only after a busy period
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("done without a busy period");

endmodule

bind gregorian_date_add_days_top gdad_chk u_chk (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done)
);

`default_nettype wire

// File: bench/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for gregorian_date_add_days_top: directed table, then random dates.
// Depends on gdad_pkg and the RTL under rtl/.

module tb;
	import gdad_pkg::*;

	localparam int          OFFSET_BITS = 12;
	localparam int unsigned OFFSET_MASK = (1 << OFFSET_BITS) - 1;
	localparam int          RANDOM_DATES = 830;

	typedef struct {
		date_in_t  stim;
		bit        pinned;
		date_out_t want;
	} date_row_t;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      start = 1'b0;
	date_in_t  item = '0;
	logic      busy;
	logic      done;
	date_out_t result;

	// expectation typed into the table, carried alongside item
	logic      pin_valid = 1'b0;
	date_out_t pin_want = '0;

	date_out_t pending_dates[$];
	date_row_t date_table[$];
	int        dates_sent = 0;
	int        dates_checked = 0;
	int        year_rollovers = 0;
	int        err_count = 0;

	gregorian_date_add_days_top #(.OFFSET_BITS(OFFSET_BITS)) uut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.item   (item),
		.busy   (busy),
		.done   (done),
		.result (result)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic int unsigned month_days(int unsigned mon, logic [YEAR_W-1:0] yr);
		int unsigned yi;
		bit          leap;
		yi = 32'(yr);
		leap = ((yi % 4) == 0 && (yi % 100) != 0) || (yi % 400) == 0;
		case (mon)
			MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: return 32'(LEN_SHORT);
			MONTH_FEB: return leap ? 32'(LEN_LEAP) : 32'(LEN_FEB);
			default: return 32'(LEN_LONG);
		endcase
	endfunction

	// walk month by month until the day fits; out-of-range months count as long ones
	function automatic date_out_t advance_date(date_in_t d);
		int unsigned       day_acc;
		int unsigned       mon;
		int unsigned       len;
		logic [YEAR_W-1:0] yr;
		date_out_t         r;
		day_acc = 32'(d.start_day) + (32'(d.days_ahead) & OFFSET_MASK);
		mon = 32'(d.start_month);
		yr = d.start_year;
		len = month_days(mon, yr);
		while (day_acc > len) begin
			day_acc -= len;
			mon++;
			if (mon > MONTH_DEC) begin
				mon = 32'(MONTH_JAN);
				yr = yr + 1'b1;
			end
			len = month_days(mon, yr);
		end
		r.end_day = day_acc[DAY_W-1:0];
		r.end_month = mon[MONTH_W-1:0];
		r.end_year = yr;
		return r;
	endfunction

	function automatic void add_row(logic [DAY_W-1:0] d, logic [MONTH_W-1:0] m,
			logic [YEAR_W-1:0] y, logic [OFFSET_FIELD_W-1:0] k, bit pinned,
			logic [DAY_W-1:0] ed, logic [MONTH_W-1:0] em, logic [YEAR_W-1:0] ey);
		date_row_t r;
		r.stim = '{start_day: d, start_month: m, start_year: y, days_ahead: k};
		r.pinned = pinned;
		r.want = '{end_day: ed, end_month: em, end_year: ey};
		date_table.push_back(r);
	endfunction

	function automatic int idle_gap(bit quiet);
		if (quiet || $urandom_range(99) >= 37)
			return 0;
		if ($urandom_range(99) < 10)
			return $urandom_range(20, 160);
		return $urandom_range(1, 8);
	endfunction

	// hold start until the block takes the transaction; leave start high for the next one
	task automatic send_date(date_in_t d, bit pinned, date_out_t want, int gap);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		item <= d;
		pin_valid <= pinned;
		pin_want <= want;
		do @(posedge clk); while (busy);
	endtask

	always @(posedge clk) begin : watch_dates
		date_out_t want;
		date_out_t got;
		if (arst_n) begin
			if (done) begin
				got = result;
				if (pending_dates.size() == 0) begin
					$error("result %0d/%0d/%0d with no transaction outstanding",
						got.end_day, got.end_month, got.end_year);
					err_count++;
				end else begin
					want = pending_dates.pop_front();
					dates_checked++;
					if (got.end_day !== want.end_day) begin
						$error("end_day: expected %0d, got %0d", want.end_day, got.end_day);
						err_count++;
					end
					if (got.end_month !== want.end_month) begin
						$error("end_month: expected %0d, got %0d", want.end_month,
							got.end_month);
						err_count++;
					end
					if (got.end_year !== want.end_year) begin
						$error("end_year: expected %0d, got %0d", want.end_year,
							got.end_year);
						err_count++;
					end
				end
			end
			if (start && !busy) begin
				want = pin_valid ? pin_want : advance_date(item);
				pending_dates.push_back(want);
				dates_sent++;
				if (want.end_year != item.start_year)
					year_rollovers++;
			end
		end
	end

	initial begin
		#20_000_000;
		$display("Timed out with %0d dates outstanding", pending_dates.size());
		$display("== FAIL ==");
		$finish;
	end

	initial begin : stimulus
		date_in_t d;
		int       sel;
		int       pick;

		// plain, year end, leap rule on all three divisors
		add_row(1, 1, 2000, 0, 1, 1, 1, 2000);
		add_row(31, 12, 2999, 1, 1, 1, 1, 3000);
		add_row(28, 2, 2024, 1, 1, 29, 2, 2024);
		add_row(28, 2, 1900, 1, 1, 1, 3, 1900);
		add_row(28, 2, 2000, 1, 1, 29, 2, 2000);
		add_row(28, 2, 2023, 1, 1, 1, 3, 2023);
		add_row(30, 11, 1999, 1, 1, 1, 12, 1999);
		// year counter wraps to zero, and zero is a leap year
		add_row(31, 12, 4095, 1, 1, 1, 1, 0);
		add_row(28, 2, 0, 1, 1, 29, 2, 0);
		// day zero, oversized days, out-of-range months
		add_row(0, 5, 100, 0, 1, 0, 5, 100);
		add_row(0, 0, 0, 0, 1, 0, 0, 0);
		add_row(31, 4, 2010, 0, 1, 1, 5, 2010);
		add_row(31, 2, 2023, 0, 1, 3, 3, 2023);
		add_row(31, 13, 2500, 1, 1, 1, 1, 2501);
		add_row(31, 0, 2500, 1, 1, 1, 1, 2500);
		add_row(0, 15, 777, 0, 1, 0, 15, 777);
		// longer walks left to the predictor
		add_row(31, 12, 4095, 4095, 0, 0, 0, 0);
		add_row(1, 1, 1, 4095, 0, 0, 0, 0);
		add_row(1, 1, 3000, 4095, 0, 0, 0, 0);
		add_row(31, 15, 4095, 4095, 0, 0, 0, 0);
		add_row(0, 15, 0, 4095, 0, 0, 0, 0);
		add_row(30, 1, 2024, 30, 0, 0, 0, 0);
		add_row(1, 1, 2100, 59, 0, 0, 0, 0);
		add_row(15, 6, 3000, 2000, 0, 0, 0, 0);
		add_row(16, 8, 1600, 1234, 0, 0, 0, 0);

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (date_table[i])
			send_date(date_table[i].stim, date_table[i].pinned, date_table[i].want,
				idle_gap(1'b0));

		for (int n = 0; n < RANDOM_DATES; n++) begin
			sel = $urandom_range(99);
			if (sel < 15) begin
				// any field value at all
				d.start_day = DAY_W'($urandom_range(31));
				d.start_month = MONTH_W'($urandom_range(15));
				d.start_year = YEAR_W'($urandom_range(4095));
				d.days_ahead = OFFSET_FIELD_W'($urandom_range(4095));
			end else begin
				if (sel < 28)
					d.start_year = YEAR_W'($urandom_range(1, 30) * 100);
				else if (sel < 32)
					d.start_year = YEAR_W'($urandom_range(2990, 3000));
				else
					d.start_year = YEAR_W'($urandom_range(1, 3000));
				d.start_month = MONTH_W'($urandom_range(1, 12));
				d.start_day = DAY_W'($urandom_range(1,
					month_days(32'(d.start_month), d.start_year)));
				pick = $urandom_range(99);
				if (pick < 35)
					d.days_ahead = OFFSET_FIELD_W'($urandom_range(62));
				else if (pick < 75)
					d.days_ahead = OFFSET_FIELD_W'($urandom_range(4095));
				else
					d.days_ahead = OFFSET_FIELD_W'($urandom_range(3500, 4095));
			end
			send_date(d, 1'b0, '0, idle_gap(n >= 300 && n < 450));
		end
		start <= 1'b0;

		@(posedge clk);
		while (pending_dates.size() != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);

		$display("Checked %0d of %0d dates (%0d from the directed table), %0d into a later year",
			dates_checked, dates_sent, date_table.size(), year_rollovers);
		$display("Mismatches and stray results: %0d", err_count);
		if (err_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
